FILE: hw/rtl/rational_accumulator_unit_defines.svh
// Assertion macros shared by the rational accumulator RTL.
`ifndef RATIONAL_ACCUMULATOR_UNIT_DEFINES_SVH
`define RATIONAL_ACCUMULATOR_UNIT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define RA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold on every rising clock edge outside reset.
`define RA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

FILE: hw/rtl/ratacc_pkg.sv
// ----------------------------------------------------------------------------
// ratacc_pkg
// Types and constants shared by the rational accumulator modules.
// ----------------------------------------------------------------------------
package ratacc_pkg;

    localparam int WORD_BITS = 32;
    localparam int WIDE_BITS = 64;

    // Command codes.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_ADD  = 1'b1;

    // Status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] operand_num;
        logic signed [31:0] operand_den;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_num;
        logic        [30:0] result_den;
        logic               is_nonzero;
        logic               less_than;
        logic               equal;
        logic        [1:0]  status;
    } out_item_t;

    // Request to and reply from the shared divider.
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

FILE: hw/rtl/ratacc_divider.sv
// ----------------------------------------------------------------------------
// ratacc_divider
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ratacc_divider
    import ratacc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  div_ctl_t               ctl,
    input  logic [WIDE_BITS-1:0]   dividend,
    input  logic [WIDE_BITS-1:0]   divisor,
    output div_sts_t               sts,
    output logic [WIDE_BITS-1:0]   quotient,
    output logic [WIDE_BITS-1:0]   remainder
);

    localparam int CNT_BITS = $clog2(WIDE_BITS + 1);

    logic [WIDE_BITS-1:0] quo_reg, quo_next;
    logic [WIDE_BITS-1:0] rem_reg, rem_next;
    logic [WIDE_BITS-1:0] dsr_reg, dsr_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [WIDE_BITS:0]   trial;
    logic [WIDE_BITS:0]   shifted;

    // One shift-and-subtract step per cycle.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[WIDE_BITS-1]};
        trial     = shifted - {1'b0, dsr_reg};
        if (ctl.start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_BITS'(WIDE_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[WIDE_BITS])
            begin
                rem_next = trial[WIDE_BITS-1:0];
                quo_next = {quo_reg[WIDE_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WIDE_BITS-1:0];
                quo_next = {quo_reg[WIDE_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: hw/rtl/rational_accumulator_unit.sv
// ----------------------------------------------------------------------------
// rational_accumulator_unit
// Keeps one reduced fraction; loads or adds operand fractions.
// ----------------------------------------------------------------------------
// Usage: an input item (cmd, operand_num, operand_den) is taken on in_valid
// with in_stall low. Each item yields one output item on out_valid, held
// until out_stall is low. in_stall is high while an item is in work or its
// output item has not been taken.
// Flow: for a zero denominator the item goes straight to ST_OUT. Otherwise
// three multiplies and the sum run in turn, then Euclid's algorithm runs
// on one shared 64-bit divider, one division per remainder step, and two
// final divisions divide numerator and denominator by the GCD. The next
// input item can be taken the cycle after the output item leaves.
// Reset clears the stored value to 0/1 and drops out_valid.
// A stalled receiver holds the output item and blocks the next input item.
// On a zero denominator, or a reduced numerator or denominator above 2^31-1
// in magnitude, the stored value is kept and the status field reports it.
// ----------------------------------------------------------------------------
`include "rational_accumulator_unit_defines.svh"

module rational_accumulator_unit
    import ratacc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL1  = 4'd1;
    localparam logic [3:0] ST_MUL2  = 4'd2;
    localparam logic [3:0] ST_MUL3  = 4'd3;
    localparam logic [3:0] ST_SUM   = 4'd4;
    localparam logic [3:0] ST_GCD   = 4'd5;
    localparam logic [3:0] ST_GWAIT = 4'd6;
    localparam logic [3:0] ST_QN    = 4'd7;
    localparam logic [3:0] ST_QD    = 4'd8;
    localparam logic [3:0] ST_CHECK = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    localparam logic [WIDE_BITS-1:0] LIMIT = WIDE_BITS'((64'd1 << (WORD_BITS - 1)) - 1);

    logic [3:0] state_reg, state_next;

    logic signed [31:0]          acc_num_reg, acc_num_next;
    logic        [30:0]          acc_den_reg, acc_den_next;
    logic                        cmd_reg, cmd_next;
    logic signed [32:0]          bn_reg, bn_next;
    logic        [31:0]          bd_reg, bd_next;
    logic signed [WIDE_BITS-1:0] l_reg, l_next;
    logic signed [WIDE_BITS-1:0] r_reg, r_next;
    logic signed [WIDE_BITS-1:0] nd_reg, nd_next;
    logic                        neg_reg, neg_next;
    logic [WIDE_BITS-1:0]        un_reg, un_next;
    logic [WIDE_BITS-1:0]        ga_reg, ga_next;
    logic [WIDE_BITS-1:0]        gb_reg, gb_next;
    logic [WIDE_BITS-1:0]        qn_reg, qn_next;
    logic [WIDE_BITS-1:0]        ud_reg, ud_next;
    logic                        lt_reg, lt_next;
    logic                        eq_reg, eq_next;
    logic [1:0]                  status_reg, status_next;
    logic                        out_valid_reg, out_valid_next;

    // Shared multiplier operands (33 x 33 signed).
    logic signed [32:0]          mul_a, mul_b;
    logic signed [65:0]          mul_p;
    logic signed [WIDE_BITS-1:0] nn;

    div_ctl_t             div_ctl;
    div_sts_t             div_sts;
    logic [WIDE_BITS-1:0] div_dividend, div_divisor, div_quo, div_rem;

    ratacc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .sts       (div_sts),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign mul_p = mul_a * mul_b;
    assign nn    = (cmd_reg == CMD_LOAD) ? WIDE_BITS'(bn_reg) : (l_reg + r_reg);

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        acc_num_next   = acc_num_reg;
        acc_den_next   = acc_den_reg;
        cmd_next       = cmd_reg;
        bn_next        = bn_reg;
        bd_next        = bd_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        nd_next        = nd_reg;
        neg_next       = neg_reg;
        un_next        = un_reg;
        ga_next        = ga_reg;
        gb_next        = gb_reg;
        qn_next        = qn_reg;
        ud_next        = ud_reg;
        lt_next        = lt_reg;
        eq_next        = eq_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        mul_a          = '0;
        mul_b          = '0;
        div_ctl.start  = 1'b0;
        div_dividend   = ga_reg;
        div_divisor    = gb_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd_next    = in_item.cmd;
                    lt_next     = 1'b0;
                    eq_next     = 1'b0;
                    status_next = STATUS_OK;
                    if (in_item.operand_den == '0)
                    begin
                        status_next = STATUS_ZERO_DEN;
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        if (in_item.operand_den < 0)
                        begin
                            bn_next = -33'(in_item.operand_num);
                            bd_next = 32'(-33'(in_item.operand_den));
                        end
                        else
                        begin
                            bn_next = 33'(in_item.operand_num);
                            bd_next = in_item.operand_den;
                        end
                        state_next = ST_MUL1;
                    end
                end
            end
            ST_MUL1:
            begin
                mul_a      = 33'(acc_num_reg);
                mul_b      = $signed({1'b0, bd_reg});
                l_next     = WIDE_BITS'(mul_p);
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                mul_a      = bn_reg;
                mul_b      = $signed({2'b0, acc_den_reg});
                r_next     = WIDE_BITS'(mul_p);
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                mul_a      = $signed({2'b0, acc_den_reg});
                mul_b      = $signed({1'b0, bd_reg});
                nd_next    = WIDE_BITS'(mul_p);
                lt_next    = l_reg < r_reg;
                eq_next    = l_reg == r_reg;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                neg_next = nn < 0;
                un_next  = nn < 0 ? WIDE_BITS'(-nn) : WIDE_BITS'(nn);
                ga_next  = nn < 0 ? WIDE_BITS'(-nn) : WIDE_BITS'(nn);
                if (cmd_reg == CMD_LOAD)
                begin
                    gb_next = WIDE_BITS'(bd_reg);
                    ud_next = WIDE_BITS'(bd_reg);
                end
                else
                begin
                    gb_next = nd_reg;
                    ud_next = nd_reg;
                end
                state_next = ST_GCD;
            end
            ST_GCD:
            begin
                if (gb_reg == '0)
                begin
                    div_ctl.start = 1'b1;
                    div_dividend  = un_reg;
                    div_divisor   = ga_reg;
                    state_next    = ST_QN;
                end
                else
                begin
                    div_ctl.start = 1'b1;
                    state_next    = ST_GWAIT;
                end
            end
            ST_GWAIT:
            begin
                if (div_sts.done)
                begin
                    ga_next    = gb_reg;
                    gb_next    = div_rem;
                    state_next = ST_GCD;
                end
            end
            ST_QN:
            begin
                if (div_sts.done)
                begin
                    qn_next       = div_quo;
                    div_ctl.start = 1'b1;
                    div_dividend  = ud_reg;
                    div_divisor   = ga_reg;
                    state_next    = ST_QD;
                end
            end
            ST_QD:
            begin
                if (div_sts.done)
                begin
                    ud_next    = div_quo;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (qn_reg > LIMIT || ud_reg > LIMIT)
                begin
                    status_next = STATUS_OVERFLOW;
                end
                else
                begin
                    acc_num_next = neg_reg ? -32'(qn_reg) : 32'(qn_reg);
                    acc_den_next = 31'(ud_reg);
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_num_reg   <= '0;
            acc_den_reg   <= 31'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_num_reg   <= acc_num_next;
            acc_den_reg   <= acc_den_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        bn_reg     <= bn_next;
        bd_reg     <= bd_next;
        l_reg      <= l_next;
        r_reg      <= r_next;
        nd_reg     <= nd_next;
        neg_reg    <= neg_next;
        un_reg     <= un_next;
        ga_reg     <= ga_next;
        gb_reg     <= gb_next;
        qn_reg     <= qn_next;
        ud_reg     <= ud_next;
        lt_reg     <= lt_next;
        eq_reg     <= eq_next;
        status_reg <= status_next;
    end

    // Output item always shows the stored value.
    assign in_stall            = (state_reg != ST_IDLE) || out_valid_reg;
    assign out_valid           = out_valid_reg;
    assign out_item.result_num = acc_num_reg;
    assign out_item.result_den = acc_den_reg;
    assign out_item.is_nonzero = acc_num_reg != '0;
    assign out_item.less_than  = lt_reg;
    assign out_item.equal      = eq_reg;
    assign out_item.status     = status_reg;

    `RA_ASSERT_ALWAYS(a_den_nonzero, clk, rst_n, acc_den_reg != '0, "stored denominator is zero")
    `RA_ASSERT_IMP(a_busy_stall, clk, rst_n, state_reg != ST_IDLE,
        in_stall, "not stalled while busy")
    `RA_ASSERT_IMP(a_one_flag, clk, rst_n, out_valid_reg && status_reg == STATUS_ZERO_DEN,
        !lt_reg && !eq_reg, "compare flags set on zero denominator")

endmodule

FILE: test/rational_accumulator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_accumulator_checker
// Watches both item channels of the rational accumulator, keeps its own copy
// of the stored fraction, predicts each output item and compares it field by
// field in order.
// ----------------------------------------------------------------------------
module rational_accumulator_checker
    import ratacc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_item,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_item,
    output int        fail_count,
    output int        pending_count
);

    localparam longint MAG_LIMIT = (64'sd1 <<< (WORD_BITS - 1)) - 1;

    // Stored fraction as the block should hold it.
    longint    frac_num;
    longint    frac_den;
    out_item_t fraction_queue[$];

    function automatic longint unsigned euclid(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // Predict one output item and update the stored fraction.
    task automatic predict_fraction(input in_item_t item);
        longint          bn;
        longint          bd;
        longint          l;
        longint          r;
        longint          nn;
        longint          nd;
        longint unsigned un;
        longint unsigned ud;
        longint unsigned g;
        out_item_t       res;
        res = '0;
        bn = longint'(item.operand_num);
        bd = longint'(item.operand_den);
        if (bd == 0)
        begin
            res.status = STATUS_ZERO_DEN;
        end
        else
        begin
            if (bd < 0)
            begin
                bn = -bn;
                bd = -bd;
            end
            l = frac_num * bd;
            r = bn * frac_den;
            res.less_than = (l < r);
            res.equal = (l == r);
            if (item.cmd == CMD_LOAD)
            begin
                nn = bn;
                nd = bd;
            end
            else
            begin
                nn = l + r;
                nd = frac_den * bd;
            end
            un = (nn < 0) ? longint'(0) - nn : nn;
            ud = nd;
            g = euclid(un, ud);
            un = un / g;
            ud = ud / g;
            if (un > MAG_LIMIT || ud > MAG_LIMIT)
            begin
                res.status = STATUS_OVERFLOW;
            end
            else
            begin
                res.status = STATUS_OK;
                frac_num = (nn < 0) ? -longint'(un) : longint'(un);
                frac_den = ud;
            end
        end
        res.result_num = frac_num[31:0];
        res.result_den = frac_den[30:0];
        res.is_nonzero = (frac_num != 0);
        fraction_queue.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %0t %s: got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // Predict on accepted inputs, check accepted outputs against the oldest.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            frac_num = 0;
            frac_den = 1;
            fraction_queue.delete();
            fail_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (fraction_queue.size() == 0)
                begin
                    report_mismatch("unexpected output item", 1, 0);
                end
                else
                begin
                    want = fraction_queue.pop_front();
                    if (out_item.result_num !== want.result_num)
                        report_mismatch("result_num", out_item.result_num, want.result_num);
                    if (out_item.result_den !== want.result_den)
                        report_mismatch("result_den", out_item.result_den, want.result_den);
                    if (out_item.is_nonzero !== want.is_nonzero)
                        report_mismatch("is_nonzero", out_item.is_nonzero, want.is_nonzero);
                    if (out_item.less_than !== want.less_than)
                        report_mismatch("less_than", out_item.less_than, want.less_than);
                    if (out_item.equal !== want.equal)
                        report_mismatch("equal", out_item.equal, want.equal);
                    if (out_item.status !== want.status)
                        report_mismatch("status", out_item.status, want.status);
                end
            end
            if (in_valid && !in_stall)
                predict_fraction(in_item);
            pending_count = fraction_queue.size();
        end
    end

endmodule

FILE: test/tb_rational_accumulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_accumulator_unit
// Drives directed and random load and add items into the rational
// accumulator with bursty input and random output stalls; a checker module
// predicts and compares every output item.
// ----------------------------------------------------------------------------
module tb_rational_accumulator_unit;
    import ratacc_pkg::*;

    localparam int RANDOM_ITEMS = 1630;
    localparam int IDLE_LIMIT   = 20000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_item;
    int        fail_count;
    int        pending_count;
    int        idle_cycles = 0;
    logic      stall_mode = 1'b0;

    always #1 clk = ~clk;

    rational_accumulator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

    rational_accumulator_checker checker_inst (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // Receiver stall pattern: alternates between calm and heavy stretches.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= ~stall_mode;
        out_stall <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b0;
    end

    // Watchdog on cycles with no accepted item on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one item and hold it until accepted.
    task automatic send_item(input logic cmd, input logic [31:0] num, input logic [31:0] den);
        in_item_t item;
        item.cmd = cmd;
        item.operand_num = num;
        item.operand_den = den;
        in_valid <= 1'b1;
        in_item <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every expected output item has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // Random operand value, biased toward small magnitudes and extremes.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0001;
            2: return 32'h8000_0000;
            3, 4: return $urandom();
            5: return 32'($urandom_range(0, 65535)) - 32'd32768;
            default: return 32'($urandom_range(0, 40)) - 32'd20;
        endcase
    endfunction

    initial
    begin
        int burst;
        logic [31:0] den;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: loads, adds, increments, zero denominators, overflow.
        send_item(CMD_LOAD, 32'd2, 32'd4);
        send_item(CMD_ADD, 32'd1, 32'd1);
        send_item(CMD_ADD, -32'sd1, 32'd1);
        send_item(CMD_LOAD, 32'd1, 32'd2);
        send_item(CMD_ADD, 32'd3, -32'sd6);
        send_item(CMD_ADD, 32'd5, 32'd0);
        send_item(CMD_LOAD, 32'd7, 32'd0);
        send_item(CMD_LOAD, 32'h8000_0000, 32'd1);
        send_item(CMD_LOAD, 32'h7FFF_FFFF, 32'd1);
        send_item(CMD_ADD, 32'd1, 32'd1);
        send_item(CMD_LOAD, 32'h8000_0001, 32'h7FFF_FFFF);
        send_item(CMD_LOAD, 32'd1, 32'h8000_0000);
        send_item(CMD_LOAD, 32'd1, 32'h7FFF_FFFF);
        send_item(CMD_ADD, 32'd1, 32'h7FFF_FFFE);
        send_item(CMD_LOAD, -32'sd3, -32'sd9);
        send_item(CMD_ADD, 32'd1, -32'sd3);
        send_item(CMD_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_ADD, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(CMD_LOAD, 32'h5555_5555, 32'hAAAA_AAAA);

        // Hold off until every output item has arrived.
        drain();

        // Random bursts, mostly adds, with operands biased toward small magnitudes.
        for (int n = 0; n < RANDOM_ITEMS; n += burst)
        begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++)
            begin
                den = ($urandom_range(0, 29) == 0) ? 32'd0 : pick_value();
                send_item(($urandom_range(0, 3) != 0) ? CMD_ADD : CMD_LOAD, pick_value(), den);
            end
            idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20));
        end

        drain();
        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
